// ===== hdl/hessian_vesselness_pixel_unit_defines.svh =====
// Assertion macros for the checker file of the vesselness pixel unit.
`ifndef HESSIAN_VESSELNESS_PIXEL_UNIT_DEFINES_SVH
`define HESSIAN_VESSELNESS_PIXEL_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HVP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HVP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/hvp_pkg.sv =====
// Package of the vesselness pixel unit: widths, register codes, sideband types, exp table.
package hvp_pkg;

  localparam int HESS_BITS     = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int CFG_BITS      = 16;
  localparam int VESS_BITS     = 16;
  localparam int EIG_BITS      = HESS_BITS + 3;
  localparam int MAG_BITS      = HESS_BITS + 2;
  localparam int SUM_BITS      = HESS_BITS + 1;
  localparam int NSQ_BITS      = 2 * HESS_BITS + 2;
  localparam int ROOT_BITS     = NSQ_BITS / 2;
  localparam int RATIO_FRAC    = 16;
  localparam int RATIO_BITS    = RATIO_FRAC + 1;
  localparam int RSQ_BITS      = 2 * RATIO_FRAC + 1;
  localparam int SSQ_BITS      = 2 * MAG_BITS;
  localparam int DEN_BITS      = 2 * CFG_BITS;
  localparam int ARG_BITS      = 23;
  localparam int EXP_BITS      = 17;
  localparam int LOG2E_BITS    = 17;
  localparam int PROD_BITS     = 33;

  localparam int IN_TDATA_BITS  = ((3 * HESS_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = VESS_BITS + 2 * EIG_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [ARG_BITS-1:0]   ARG_MAX   = ARG_BITS'(1) << (ARG_BITS - 1);
  localparam logic [LOG2E_BITS-1:0] LOG2E_Q16 = LOG2E_BITS'(94548);
  localparam logic [CFG_BITS-1:0]   BETA_RST  = CFG_BITS'(2048);
  localparam logic [CFG_BITS-1:0]   SCALE_RST = CFG_BITS'(256);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_BETA  = 1'b0,
    CFG_SCALE = 1'b1
  } cfg_reg_e;

  // Sideband through the ratio divider
  typedef struct packed {
    logic [EIG_BITS-1:0] major;
    logic [EIG_BITS-1:0] minor;
    logic [MAG_BITS-1:0] um;
    logic [MAG_BITS-1:0] un;
    logic                ok;
  } qdiv_side_t;

  // Sideband through the blobness divider
  typedef struct packed {
    logic [EIG_BITS-1:0] major;
    logic [EIG_BITS-1:0] minor;
  } eig_side_t;

  // 2^(-i/8) in Q16, i = 0..8
  function automatic logic [EXP_BITS-1:0] pow2_neg_eighth(input logic [3:0] idx);
    logic [EXP_BITS-1:0] v;
    unique case (idx)
      4'd0:    v = EXP_BITS'(65536);
      4'd1:    v = EXP_BITS'(60097);
      4'd2:    v = EXP_BITS'(55109);
      4'd3:    v = EXP_BITS'(50535);
      4'd4:    v = EXP_BITS'(46341);
      4'd5:    v = EXP_BITS'(42495);
      4'd6:    v = EXP_BITS'(38968);
      4'd7:    v = EXP_BITS'(35734);
      4'd8:    v = EXP_BITS'(32768);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hvp_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
module hvp_isqrt_pipe #(
  parameter int NW = hvp_pkg::NSQ_BITS,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     n_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [NW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int ST = NW / 2;

  logic [NW-1:0] n_q    [ST];
  logic [NW-1:0] res_q  [ST];
  logic [SW-1:0] side_q [ST];
  logic          vld_q  [ST];

  for (genvar j = 0; j < ST; j++) begin : g_stage
    logic [NW-1:0] n_in, res_in, n_d, res_d, bit_c;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [NW:0]   t_c;
    logic          ge_c;

    // Stage input: the request port or the previous stage
    if (j == 0) begin : g_first
      assign n_in    = n_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign n_in    = n_q[j-1];
      assign res_in  = res_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    // One digit: try to subtract res + bit
    always_comb begin
      bit_c = NW'(1) << (NW - 2 - 2 * j);
      t_c   = {1'b0, res_in} + {1'b0, bit_c};
      ge_c  = {1'b0, n_in} >= t_c;
      n_d   = ge_c ? (n_in - t_c[NW-1:0]) : n_in;
      res_d = ge_c ? ((res_in >> 1) + bit_c) : (res_in >> 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]    <= n_d;
        res_q[j]  <= res_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ST-1];
  assign root_o  = res_q[ST-1][NW/2-1:0];
  assign side_o  = side_q[ST-1];

endmodule

// ===== hdl/hvp_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module hvp_div_pipe #(
  parameter int DW = hvp_pkg::DEN_BITS,
  parameter int RW = hvp_pkg::DEN_BITS,
  parameter int K  = hvp_pkg::ARG_BITS,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,   // dividend bits above the K shifted in
  input  logic [K-1:0]  low_i,   // dividend bits shifted in, MSB first
  input  logic [DW-1:0] div_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [K-1:0]  quo_o,
  output logic          sat_o,   // quotient does not fit in K bits
  output logic [SW-1:0] side_o
);

  localparam int CW = ((RW > DW) ? RW : DW) + 1;

  logic [DW-1:0] rem_q  [K];
  logic [K-1:0]  low_q  [K];
  logic [K-1:0]  quo_q  [K];
  logic [DW-1:0] div_q  [K];
  logic          sat_q  [K];
  logic [SW-1:0] side_q [K];
  logic          vld_q  [K];

  logic sat0;
  assign sat0 = CW'(rem_i) >= CW'(div_i);

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [DW-1:0] rem_in, div_in, rem_d;
    logic [K-1:0]  low_in, quo_in;
    logic [SW-1:0] side_in;
    logic          sat_in, vld_in;
    logic [DW:0]   t_c;
    logic          ge_c;

    // Stage input: the request port or the previous stage
    if (j == 0) begin : g_first
      assign rem_in  = sat0 ? '0 : DW'(rem_i);
      assign low_in  = low_i;
      assign quo_in  = '0;
      assign div_in  = div_i;
      assign sat_in  = sat0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign low_in  = low_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign div_in  = div_q[j-1];
      assign sat_in  = sat_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    // Shift in the next dividend bit and try the subtract
    always_comb begin
      t_c   = {rem_in, low_in[K-1]};
      ge_c  = t_c >= {1'b0, div_in};
      rem_d = ge_c ? DW'(t_c - {1'b0, div_in}) : t_c[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        low_q[j]  <= low_in << 1;
        quo_q[j]  <= {quo_in[K-2:0], ge_c};
        div_q[j]  <= div_in;
        sat_q[j]  <= sat_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[K-1];
  assign quo_o   = quo_q[K-1];
  assign sat_o   = sat_q[K-1];
  assign side_o  = side_q[K-1];

endmodule

// ===== hdl/hessian_vesselness_pixel_unit.sv =====
// Top level of the Frangi vesselness pixel unit: stream ports, config and pipeline.
// Takes one pixel per clock while the output is not held and returns one result
// per pixel, in order. The pipeline holds the pipelined square root (17 stages),
// the eigenvalue ratio divider (16 stages) and the two argument dividers (23
// stages), each giving one result bit per stage, plus eleven stages of squaring,
// exp and product. The whole pipeline advances when the output register is empty
// or being taken; the input tready is that advance condition. The user must write
// configuration only while no pixel is in flight; the block does not enforce it.
module hessian_vesselness_pixel_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [hvp_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,  // hess_xx, hess_yy, hess_xy
  input  logic [0:0]                          s_axis_tuser_i,  // masked_out
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // vesselness, eigen_major_x2, eigen_minor_x2, zero pad
  output logic [hvp_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [hvp_pkg::CFG_BITS-1:0]        cfg_wdata_i
);

  localparam int HB  = hvp_pkg::HESS_BITS;
  localparam int EB  = hvp_pkg::EIG_BITS;
  localparam int MB  = hvp_pkg::MAG_BITS;
  localparam int SB  = hvp_pkg::SUM_BITS;
  localparam int NB  = hvp_pkg::NSQ_BITS;
  localparam int RB  = hvp_pkg::ROOT_BITS;
  localparam int QB  = hvp_pkg::RATIO_BITS;
  localparam int QF  = hvp_pkg::RATIO_FRAC;
  localparam int RQB = hvp_pkg::RSQ_BITS;
  localparam int SQB = hvp_pkg::SSQ_BITS;
  localparam int DB  = hvp_pkg::DEN_BITS;
  localparam int AB  = hvp_pkg::ARG_BITS;
  localparam int XB  = hvp_pkg::EXP_BITS;
  localparam int LB  = hvp_pkg::LOG2E_BITS;
  localparam int PB  = hvp_pkg::PROD_BITS;
  localparam int VB  = hvp_pkg::VESS_BITS;
  localparam int OF  = hvp_pkg::OUT_FRAC_BITS;
  localparam int CB  = hvp_pkg::CFG_BITS;
  // dividend splits: blobness rq*128 and structureness s*2^13 over 23 quotient bits
  localparam int BHI = AB - 7;
  localparam int SHI = AB - 13;

  // ---------------- configuration registers
  logic [CB-1:0] beta_q, beta_d, scale_q, scale_d;

  always_comb begin
    beta_d  = beta_q;
    scale_d = scale_q;
    if (cfg_we_i) begin
      unique case (hvp_pkg::cfg_reg_e'(cfg_index_i))
        hvp_pkg::CFG_BETA:  beta_d  = cfg_wdata_i;
        hvp_pkg::CFG_SCALE: scale_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q  <= hvp_pkg::BETA_RST;
      scale_q <= hvp_pkg::SCALE_RST;
    end else begin
      beta_q  <= beta_d;
      scale_q <= scale_d;
    end
  end

  // ---------------- global advance
  logic out_valid_q;
  logic [hvp_pkg::OUT_TDATA_BITS-1:0] out_data_q;
  logic en;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------- stage 1: differences and magnitudes
  logic [HB-1:0] xx, yy, xy, uxy_c, ud_c;
  logic [SB-1:0] diff_c, sum_c;

  always_comb begin
    xx     = s_axis_tdata_i[HB-1:0];
    yy     = s_axis_tdata_i[2*HB-1:HB];
    xy     = s_axis_tdata_i[3*HB-1:2*HB];
    diff_c = {xx[HB-1], xx} - {yy[HB-1], yy};
    sum_c  = {xx[HB-1], xx} + {yy[HB-1], yy};
    ud_c   = diff_c[SB-1] ? HB'(-diff_c) : diff_c[HB-1:0];
    uxy_c  = xy[HB-1] ? (-xy) : xy;
  end

  logic          v1_q, v2_q, v3_q;
  logic [HB-1:0] ud1_q, uxy1_q;
  logic [SB-1:0] sum1_q, sum2_q, sum3_q;
  logic          msk1_q, msk2_q, msk3_q;
  logic [2*HB-1:0] pd2_q, px2_q;
  logic [NB-1:0] n3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stages 1 to 3: squares, then the discriminant
  always_ff @(posedge clk_i) begin
    if (en) begin
      ud1_q  <= ud_c;
      uxy1_q <= uxy_c;
      sum1_q <= sum_c;
      msk1_q <= s_axis_tuser_i[0];
      pd2_q  <= ud1_q * ud1_q;
      px2_q  <= uxy1_q * uxy1_q;
      sum2_q <= sum1_q;
      msk2_q <= msk1_q;
      n3_q   <= {2'b00, pd2_q} + {px2_q, 2'b00};
      sum3_q <= sum2_q;
      msk3_q <= msk2_q;
    end
  end

  // ---------------- square root
  logic          vr;
  logic [RB-1:0] root;
  logic [SB:0]   rside;

  hvp_isqrt_pipe #(.NW(NB), .SW(SB + 1)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .n_i     (n3_q),
    .side_i  ({sum3_q, msk3_q}),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (rside)
  );

  // ---------------- stage 4: eigenvalues and ordering by magnitude
  logic [EB-1:0] sum_e, root_e, l1, l2, a1, a2, maj_c, min_c, amaj_c, amin_c;
  logic          ok_c;

  always_comb begin
    sum_e  = {{(EB - SB){rside[SB]}}, rside[SB:1]};
    root_e = EB'(root);
    l1     = sum_e + root_e;
    l2     = sum_e - root_e;
    a1     = l1[EB-1] ? -l1 : l1;
    a2     = l2[EB-1] ? -l2 : l2;
    maj_c  = (a1 < a2) ? l2 : l1;
    min_c  = (a1 < a2) ? l1 : l2;
    amaj_c = (a1 < a2) ? a2 : a1;
    amin_c = (a1 < a2) ? a1 : a2;
    ok_c   = !rside[0] && !maj_c[EB-1] && (maj_c != '0);
  end

  logic v4_q;
  hvp_pkg::qdiv_side_t s4_q, s5in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.major <= maj_c;
      s4_q.minor <= min_c;
      s4_q.um    <= amaj_c[MB-1:0];
      s4_q.un    <= amin_c[MB-1:0];
      s4_q.ok    <= ok_c;
    end
  end

  // ---------------- ratio |minor| * 2^16 / major
  logic          vq, qsat;
  logic [QF-1:0] qquo;

  hvp_div_pipe #(.DW(MB), .RW(MB), .K(QF), .SW($bits(hvp_pkg::qdiv_side_t))) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rem_i   (s4_q.un),
    .low_i   ('0),
    .div_i   (s4_q.um),
    .side_i  (s4_q),
    .valid_o (vq),
    .quo_o   (qquo),
    .sat_o   (qsat),
    .side_o  (s5in)
  );

  // ---------------- stages 5 and 6: squares of ratio, eigenvalues and config
  logic [QB-1:0]  q_c;
  logic [2*QB-1:0] rq_full;
  logic           v5_q, v6_q;
  logic [RQB-1:0] rq5_q, rq6_q;
  logic [SQB-1:0] sqm5_q, sqn5_q, s6_q;
  logic [DB-1:0]  bsq5_q, csq5_q, bsq6_q, csq6_q;
  hvp_pkg::eig_side_t e5_q, e6_q;
  logic           ok5_q, ok6_q;

  assign q_c     = qsat ? (QB'(1) << QF) : {1'b0, qquo};
  assign rq_full = q_c * q_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= vq;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq5_q   <= rq_full[RQB-1:0];
      sqm5_q  <= s5in.um * s5in.um;
      sqn5_q  <= s5in.un * s5in.un;
      bsq5_q  <= beta_q * beta_q;
      csq5_q  <= scale_q * scale_q;
      e5_q    <= '{major: s5in.major, minor: s5in.minor};
      ok5_q   <= s5in.ok;
      rq6_q   <= rq5_q;
      s6_q    <= SQB'({1'b0, sqm5_q} + {1'b0, sqn5_q});
      bsq6_q  <= bsq5_q;
      csq6_q  <= csq5_q;
      e6_q    <= e5_q;
      ok6_q   <= ok5_q;
    end
  end

  // ---------------- exp arguments: blobness and structureness divisions
  logic          vb, vs, bsat, ssat, ok_s;
  logic [AB-1:0] bquo, squo;
  hvp_pkg::eig_side_t e7in;

  hvp_div_pipe #(.DW(DB), .RW(RQB - BHI), .K(AB), .SW($bits(hvp_pkg::eig_side_t))) u_bdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rem_i   (rq6_q[RQB-1:BHI]),
    .low_i   ({rq6_q[BHI-1:0], 7'b0}),
    .div_i   (bsq6_q),
    .side_i  (e6_q),
    .valid_o (vb),
    .quo_o   (bquo),
    .sat_o   (bsat),
    .side_o  (e7in)
  );

  hvp_div_pipe #(.DW(DB), .RW(SQB - SHI), .K(AB), .SW(1)) u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rem_i   (s6_q[SQB-1:SHI]),
    .low_i   ({s6_q[SHI-1:0], 13'b0}),
    .div_i   (csq6_q),
    .side_i  (ok6_q),
    .valid_o (vs),
    .quo_o   (squo),
    .sat_o   (ssat),
    .side_o  (ok_s)
  );

  // ---------------- stages 7 to 9: exp(-x) for both arguments
  logic [AB-1:0]    arg_c [2];
  logic [AB+LB-1:0] ymul_c [2];
  logic [AB-1:0]    y7_q [2];
  logic [XB-1:0]    hi_c [2], lo_c [2], hi8_q [2], ex_c [2], ex9_q [2];
  logic [XB-1:0]    dl_c [2];
  logic [XB+12:0]   cor8_q [2];
  logic             kz8_q [2];
  logic [4:0]       sh8_q [2];
  logic             v7_q, v8_q, v9_q, v10_q;
  hvp_pkg::eig_side_t e7_q, e8_q, e9_q, e10_q;
  logic             ok7_q, ok8_q, ok9_q, ok10_q;

  always_comb begin
    arg_c[0] = (bsat || (bquo > hvp_pkg::ARG_MAX)) ? hvp_pkg::ARG_MAX : bquo;
    arg_c[1] = (ssat || (squo > hvp_pkg::ARG_MAX)) ? hvp_pkg::ARG_MAX : squo;
    for (int i = 0; i < 2; i++) begin
      ymul_c[i] = (AB + LB)'(arg_c[i]) * (AB + LB)'(hvp_pkg::LOG2E_Q16);
      hi_c[i]   = hvp_pkg::pow2_neg_eighth({1'b0, y7_q[i][15:13]});
      lo_c[i]   = hvp_pkg::pow2_neg_eighth(4'({1'b0, y7_q[i][15:13]} + 4'd1));
      dl_c[i]   = hi_c[i] - lo_c[i];
      ex_c[i]   = kz8_q[i] ? '0 :
                  ((hi8_q[i] - XB'(cor8_q[i] >> 13)) >> sh8_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v7_q  <= vb && vs;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        y7_q[i]   <= ymul_c[i][AB+15:16];
        hi8_q[i]  <= hi_c[i];
        cor8_q[i] <= dl_c[i] * y7_q[i][12:0];
        kz8_q[i]  <= y7_q[i][AB-1:16] >= 7'd17;
        sh8_q[i]  <= y7_q[i][20:16];
        ex9_q[i]  <= ex_c[i];
      end
      e7_q  <= e7in;
      ok7_q <= ok_s;
      e8_q  <= e7_q;
      ok8_q <= ok7_q;
      e9_q  <= e8_q;
      ok9_q <= ok8_q;
      e10_q <= e9_q;
      ok10_q <= ok9_q;
    end
  end

  // ---------------- stage 10: product, stage 11: scale and output register
  logic [2*XB-1:0] p_c;
  logic [PB-1:0]   p10_q, vsh_c, lim_c, vv_c;

  assign p_c   = ex9_q[0] * (XB'(1 << 16) - ex9_q[1]);
  assign vsh_c = p10_q >> (32 - OF);
  assign lim_c = (PB'(1) << OF) - PB'(1);
  assign vv_c  = (vsh_c > lim_c) ? lim_c : vsh_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p10_q <= p_c[PB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {{(hvp_pkg::OUT_TDATA_BITS - hvp_pkg::OUT_FIELD_BITS){1'b0}},
                     e10_q.minor, e10_q.major,
                     ok10_q ? vv_c[VB-1:0] : {VB{1'b0}}};
    end
  end

endmodule

// ===== hdl/hvp_checker.sv =====
// Port-level checker of the vesselness pixel unit, bound to the top level.
`include "hessian_vesselness_pixel_unit_defines.svh"

module hvp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tready_i,
  input logic                               m_tvalid_i,
  input logic                               m_tready_i,
  input logic [hvp_pkg::OUT_TDATA_BITS-1:0] m_tdata_i
);

  localparam int VB = hvp_pkg::VESS_BITS;
  localparam int EB = hvp_pkg::EIG_BITS;

  logic nonpos_major;
  assign nonpos_major = m_tdata_i[VB+EB-1] || (m_tdata_i[VB+EB-1:VB] == '0);

  // a held request keeps its valid and its data
  `HVP_ASSERT_NXT(a_hold_valid, m_tvalid_i && !m_tready_i, m_tvalid_i)
  `HVP_ASSERT_NXT(a_hold_data, m_tvalid_i && !m_tready_i, $stable(m_tdata_i))

  // an empty output stage never blocks the input side
  `HVP_ASSERT_IMP(a_ready_free, !m_tvalid_i, s_tready_i)

  // a non-positive major eigenvalue gives zero vesselness
  `HVP_ASSERT_IMP(a_nonpos_major, m_tvalid_i && nonpos_major, m_tdata_i[VB-1:0] == '0)

endmodule

bind hessian_vesselness_pixel_unit hvp_checker u_hvp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
